// ----- src/rcp_pkg.sv -----
// Shared types, constants and helper functions for the robot collision predictor.
// Used by every module in src but rcp_checker; depends on nothing.
`timescale 1ns / 1ps

package rcp_pkg;

    localparam int ROBOT_COUNT = 8;
    localparam int RIDX_W      = $clog2(ROBOT_COUNT);

    // Configuration register indexes
    localparam logic [1:0] CFG_OWN_INDEX      = 2'd0;
    localparam logic [1:0] CFG_TICK_MS        = 2'd1;
    localparam logic [1:0] CFG_DEADLOCK_LIMIT = 2'd2;

    // Angles and unit values in Q30
    localparam logic signed [35:0] Q30_ONE     = 36'sd1073741824;
    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [4:0]         CORDIC_LAST = 5'd29;

    // Squared near distance, Q4 mm
    localparam logic [66:0] NEAR_SQ = 67'd1600000000;

    // Turn angle 9*|w|*2^26/125 split as |9w|*536870 + |9w|*114/125;
    // the last quotient uses a reciprocal, exact for products below 2^23
    localparam logic [19:0] TURN_INT   = 20'd536870;
    localparam logic [6:0]  TURN_FRAC  = 7'd114;
    localparam logic [23:0] TURN_RECIP = 24'd8589935;

    localparam logic [5:0]  DIV_LAST     = 6'd41;

    typedef enum logic [2:0] {
        CR_IDLE,
        CR_REDUCE,
        CR_FOLD,
        CR_ITER,
        CR_DONE
    } cordic_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_DONE
    } div_state_t;

    typedef enum logic [4:0] {
        LN_IDLE,
        LN_LOAD,
        LN_TDIV,
        LN_TANG,
        LN_TCOR,
        LN_MS,
        LN_DXS,
        LN_DXW,
        LN_MC,
        LN_DYS,
        LN_DYW,
        LN_HEAD,
        LN_HCOR,
        LN_R1,
        LN_R2,
        LN_R3,
        LN_R4,
        LN_R5,
        LN_DONE
    } lane_state_t;

    typedef enum logic [2:0] {
        MG_IDLE,
        MG_S1,
        MG_S2,
        MG_S3,
        MG_S4,
        MG_S5,
        MG_DONE
    } merge_state_t;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_LANES,
        TS_MERGE,
        TS_RESULT
    } top_state_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } lane_res_t;

    typedef struct packed {
        logic done;
        logic near;
    } merge_res_t;

    // Arithmetic right shift that rounds toward zero
    function automatic logic signed [67:0] tshr(input logic signed [67:0] v,
                                                input logic [5:0] sh);
        logic [67:0] mag;
        logic [67:0] q;
        mag = v[67] ? 68'(-v) : 68'(v);
        q   = mag >> sh;
        return v[67] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
        logic signed [35:0] r;
        case (i)
            5'd0:    r = 36'sd843314856;
            5'd1:    r = 36'sd497837829;
            5'd2:    r = 36'sd263043836;
            5'd3:    r = 36'sd133525158;
            5'd4:    r = 36'sd67021686;
            5'd5:    r = 36'sd33543515;
            5'd6:    r = 36'sd16775850;
            5'd7:    r = 36'sd8388437;
            5'd8:    r = 36'sd4194282;
            5'd9:    r = 36'sd2097149;
            5'd10:   r = 36'sd1048575;
            5'd11:   r = 36'sd524287;
            5'd12:   r = 36'sd262143;
            5'd13:   r = 36'sd131071;
            5'd14:   r = 36'sd65535;
            5'd15:   r = 36'sd32767;
            5'd16:   r = 36'sd16383;
            5'd17:   r = 36'sd8191;
            5'd18:   r = 36'sd4095;
            5'd19:   r = 36'sd2047;
            5'd20:   r = 36'sd1024;
            5'd21:   r = 36'sd511;
            5'd22:   r = 36'sd255;
            5'd23:   r = 36'sd127;
            5'd24:   r = 36'sd63;
            5'd25:   r = 36'sd31;
            5'd26:   r = 36'sd15;
            5'd27:   r = 36'sd8;
            5'd28:   r = 36'sd4;
            5'd29:   r = 36'sd2;
            default: r = 36'sd0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/robot_collision_predictor_top.sv -----
// Top level of the robot collision predictor: channels, wait timers, result register.
// Instantiates two rcp_lane copies and rcp_merge; depends on rcp_pkg.
`timescale 1ns / 1ps

// Each request on the input channel (in_valid/in_ready) carries both robots'
// poses and velocities and the index of the other robot. The block answers
// every request with exactly one result on the output channel
// (out_valid/out_ready): skipped, approaching, stop_and_wait and deadlock.
// Two lanes project the own and the peer pose in parallel; the merge stage
// then compares squared distances and the wait timers are updated.
// A skipped request (other index equal to own index) goes straight to the
// result register. Otherwise a lane with nonzero turn rate forms the turn
// angle, then runs two divisions and two CORDIC passes; with zero turn rate
// a lane runs only the heading CORDIC pass. The merge follows. One request
// is in work at a time: a new request is taken only once the last result
// has moved on to the output register.
// The result sits in an output register: while the receiver stalls, the
// block still accepts and works on the next request, and holds its result
// until the register frees. Configuration (cfg_valid/cfg_ready, cfg_index,
// cfg_data) is always ready and is to be written only while idle.
// Reset clears the registers to own_index 0, tick_ms 100, limit 5000 ms,
// all wait timers to zero, and empties the output register.

module robot_collision_predictor_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         other_index,
    input  logic signed [23:0] own_x,
    input  logic signed [23:0] own_y,
    input  logic signed [15:0] own_heading,
    input  logic signed [12:0] own_speed,
    input  logic signed [12:0] own_turn_rate,
    input  logic signed [23:0] peer_x,
    input  logic signed [23:0] peer_y,
    input  logic signed [15:0] peer_heading,
    input  logic signed [12:0] peer_speed,
    input  logic signed [12:0] peer_turn_rate,
    input  logic               driving,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               skipped,
    output logic               approaching,
    output logic               stop_and_wait,
    output logic               deadlock
);
    import rcp_pkg::*;

    top_state_t         state_reg, state_next;
    logic [2:0]         own_index_reg;
    logic [9:0]         tick_reg;
    logic [15:0]        limit_reg;
    logic [15:0]        timer_reg [ROBOT_COUNT];

    logic [2:0]         other_reg;
    logic signed [23:0] ox_reg, oy_reg, qx_reg, qy_reg;
    logic               rs_skip_reg, rs_appr_reg, rs_saw_reg, rs_dl_reg;
    logic               out_valid_reg;
    logic               out_skip_reg, out_appr_reg, out_saw_reg, out_dl_reg;

    logic               accept;
    logic               skip_now;
    logic               lane_start;
    logic               merge_start;
    logic               merge_finish;
    logic               load_out;
    lane_res_t          own_res, peer_res;
    merge_res_t         mres;

    logic [15:0]        timer_cur;
    logic [16:0]        t_sum;
    logic [15:0]        t_sat;
    logic               upd;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == TS_IDLE);
    assign accept    = in_valid && in_ready;
    assign skip_now  = (other_index == own_index_reg)
                    || ({4'd0, other_index} >= 7'(ROBOT_COUNT));
    assign lane_start   = accept && !skip_now;
    assign merge_start  = (state_reg == TS_LANES) && own_res.done && peer_res.done;
    assign merge_finish = (state_reg == TS_MERGE) && mres.done;
    assign load_out     = (state_reg == TS_RESULT) && (!out_valid_reg || out_ready);

    assign timer_cur = timer_reg[other_reg[RIDX_W-1:0]];
    assign t_sum     = {1'b0, timer_cur} + {7'd0, tick_reg};
    assign t_sat     = t_sum[16] ? 16'hFFFF : t_sum[15:0];
    assign upd       = mres.near && (timer_cur < limit_reg);

    rcp_lane u_lane_own (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (lane_start),
        .pos_x     (own_x),
        .pos_y     (own_y),
        .heading   (own_heading),
        .speed     (own_speed),
        .turn_rate (own_turn_rate),
        .res       (own_res)
    );

    rcp_lane u_lane_peer (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (lane_start),
        .pos_x     (peer_x),
        .pos_y     (peer_y),
        .heading   (peer_heading),
        .speed     (peer_speed),
        .turn_rate (peer_turn_rate),
        .res       (peer_res)
    );

    rcp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (merge_start),
        .own_x     (ox_reg),
        .own_y     (oy_reg),
        .peer_x    (qx_reg),
        .peer_y    (qy_reg),
        .own_pred  (own_res),
        .peer_pred (peer_res),
        .res       (mres)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TS_IDLE:
            begin
                if (accept)
                    state_next = skip_now ? TS_RESULT : TS_LANES;
            end
            TS_LANES:
            begin
                if (merge_start)
                    state_next = TS_MERGE;
            end
            TS_MERGE:
            begin
                if (merge_finish)
                    state_next = TS_RESULT;
            end
            TS_RESULT:
            begin
                if (load_out)
                    state_next = TS_IDLE;
            end
            default: state_next = TS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= TS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_index_reg <= 3'd0;
            tick_reg      <= 10'd100;
            limit_reg     <= 16'd5000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OWN_INDEX:      own_index_reg <= cfg_data[2:0];
                CFG_TICK_MS:        tick_reg      <= cfg_data[9:0];
                CFG_DEADLOCK_LIMIT: limit_reg     <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Wait timers: drop all when not driving, when not approaching, or at limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROBOT_COUNT; i++)
                timer_reg[i] <= '0;
        end
        else if (accept && !driving)
        begin
            for (int i = 0; i < ROBOT_COUNT; i++)
                timer_reg[i] <= '0;
        end
        else if (merge_finish)
        begin
            if (upd)
                timer_reg[other_reg[RIDX_W-1:0]] <= t_sat;
            else
            begin
                for (int i = 0; i < ROBOT_COUNT; i++)
                    timer_reg[i] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            other_reg   <= other_index;
            ox_reg      <= own_x;
            oy_reg      <= own_y;
            qx_reg      <= peer_x;
            qy_reg      <= peer_y;
            rs_skip_reg <= skip_now;
            rs_appr_reg <= 1'b0;
            rs_saw_reg  <= 1'b0;
            rs_dl_reg   <= 1'b0;
        end
        else if (merge_finish)
        begin
            rs_appr_reg <= mres.near;
            rs_saw_reg  <= upd && (own_index_reg > other_reg);
            rs_dl_reg   <= upd && (t_sat > limit_reg);
        end
        if (load_out)
        begin
            out_skip_reg <= rs_skip_reg;
            out_appr_reg <= rs_appr_reg;
            out_saw_reg  <= rs_saw_reg;
            out_dl_reg   <= rs_dl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid     = out_valid_reg;
    assign skipped       = out_skip_reg;
    assign approaching   = out_appr_reg;
    assign stop_and_wait = out_saw_reg;
    assign deadlock      = out_dl_reg;

endmodule

// ----- src/rcp_divider.sv -----
// Iterative unsigned restoring divider, one quotient bit per cycle.
// 42-bit dividend, 13-bit nonzero divisor; depends on rcp_pkg.
`timescale 1ns / 1ps

module rcp_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [41:0] dividend,
    input  logic [12:0] divisor,
    output logic [41:0] quotient,
    output logic        done
);
    import rcp_pkg::*;

    div_state_t  state_reg, state_next;
    logic [5:0]  cnt_reg;
    logic [41:0] quo_reg;
    logic [12:0] rem_reg;
    logic [12:0] dsr_reg;
    logic [13:0] trial;
    logic        fits;

    assign trial = {rem_reg, quo_reg[41]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DV_IDLE, DV_DONE:
            begin
                if (start)
                    state_next = DV_RUN;
            end
            DV_RUN:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = DV_DONE;
            end
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= DV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg != DV_RUN && start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
            cnt_reg <= '0;
        end
        else if (state_reg == DV_RUN)
        begin
            rem_reg <= fits ? 13'(trial - {1'b0, dsr_reg}) : trial[12:0];
            quo_reg <= {quo_reg[40:0], fits};
            cnt_reg <= cnt_reg + 6'd1;
        end
    end

    assign quotient = quo_reg;
    assign done     = (state_reg == DV_DONE);

endmodule

// ----- src/rcp_cordic.sv -----
// Iterative 30-step CORDIC for sine and cosine in Q30, with range reduction.
// Depends on rcp_pkg for angle constants and the arctangent table.
`timescale 1ns / 1ps

module rcp_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [35:0] angle,
    output logic signed [33:0] cos_out,
    output logic signed [33:0] sin_out,
    output logic               done
);
    import rcp_pkg::*;

    cordic_state_t      state_reg, state_next;
    logic [35:0]        mag_reg;
    logic               neg_reg;
    logic               flip_reg;
    logic [4:0]         step_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [35:0] z_reg;
    logic signed [35:0] red;
    logic signed [35:0] wrapped;
    logic signed [35:0] folded;
    logic               fold_flip;
    logic signed [33:0] x_sh, y_sh;

    always_comb
    begin
        red     = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
        wrapped = red;
        if (red > Q30_PI)
            wrapped = red - Q30_TWO_PI;
        else if (red < -Q30_PI)
            wrapped = red + Q30_TWO_PI;
        folded    = wrapped;
        fold_flip = 1'b0;
        if (wrapped > Q30_HALF_PI)
        begin
            folded    = Q30_PI - wrapped;
            fold_flip = 1'b1;
        end
        else if (wrapped < -Q30_HALF_PI)
        begin
            folded    = -Q30_PI - wrapped;
            fold_flip = 1'b1;
        end
    end

    assign x_sh = 34'(tshr(68'(x_reg), 6'(step_reg)));
    assign y_sh = 34'(tshr(68'(y_reg), 6'(step_reg)));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CR_IDLE, CR_DONE:
            begin
                if (start)
                    state_next = CR_REDUCE;
            end
            CR_REDUCE:
            begin
                if (mag_reg < 36'(Q30_TWO_PI))
                    state_next = CR_FOLD;
            end
            CR_FOLD:   state_next = CR_ITER;
            CR_ITER:
            begin
                if (step_reg == CORDIC_LAST)
                    state_next = CR_DONE;
            end
            default:   state_next = CR_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CR_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == CR_IDLE || state_reg == CR_DONE) && start)
        begin
            neg_reg <= angle[35];
            mag_reg <= angle[35] ? 36'(-angle) : 36'(angle);
        end
        else if (state_reg == CR_REDUCE)
        begin
            if (mag_reg >= 36'(Q30_TWO_PI))
                mag_reg <= mag_reg - 36'(Q30_TWO_PI);
        end
        else if (state_reg == CR_FOLD)
        begin
            z_reg    <= folded;
            flip_reg <= fold_flip;
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            step_reg <= '0;
        end
        else if (state_reg == CR_ITER)
        begin
            if (!z_reg[35])
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_q30(step_reg);
            end
            else
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_q30(step_reg);
            end
            step_reg <= step_reg + 5'd1;
        end
    end

    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = y_reg;
    assign done    = (state_reg == CR_DONE);

endmodule

// ----- src/rcp_lane.sv -----
// One prediction lane: projects a robot pose 4.5 s ahead along its arc.
// Holds a divider, a CORDIC and one shared multiplier, plus products by constants; depends on rcp_pkg.
`timescale 1ns / 1ps

module rcp_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [23:0] pos_x,
    input  logic signed [23:0] pos_y,
    input  logic signed [15:0] heading,
    input  logic signed [12:0] speed,
    input  logic signed [12:0] turn_rate,
    output rcp_pkg::lane_res_t res
);
    import rcp_pkg::*;

    lane_state_t        state_reg, state_next;
    logic signed [23:0] x_reg, y_reg;
    logic signed [15:0] h_reg;
    logic signed [12:0] v_reg, w_reg;
    logic signed [33:0] c_reg, s_reg;
    logic signed [33:0] dx_reg, dy_reg;
    logic signed [67:0] prod_reg, acc_reg;
    logic               sgn_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [22:0]        turn_frac_reg;
    logic [34:0]        turn_base_reg;
    logic [34:0]        turn_reg;

    logic [12:0]        w_mag;
    logic [15:0]        turn_n;
    logic [46:0]        turn_prod;
    logic signed [33:0] kv;
    logic [67:0]        prod_mag;
    logic signed [33:0] mul_a, mul_b;
    logic signed [33:0] quo_s;

    logic               div_start, div_done;
    logic [41:0]        div_dividend, div_quo;
    logic [12:0]        div_divisor;
    logic               cor_start, cor_done;
    logic signed [35:0] cor_angle;
    logic signed [33:0] cor_cos, cor_sin;

    assign w_mag     = w_reg[12] ? (~w_reg + 13'd1) : w_reg;
    assign turn_n    = 16'(w_mag) * 16'd9;
    assign turn_prod = 47'(turn_frac_reg) * 47'(TURN_RECIP);
    assign kv        = 34'(v_reg) * 34'sd1000;
    assign prod_mag  = prod_reg[67] ? 68'(-prod_reg) : 68'(prod_reg);
    assign quo_s     = sgn_reg ? -$signed(34'(div_quo)) : $signed(34'(div_quo));

    rcp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .done     (div_done)
    );

    rcp_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .cos_out (cor_cos),
        .sin_out (cor_sin),
        .done    (cor_done)
    );

    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = prod_mag[67:26];
        div_divisor  = w_mag;
        cor_start    = 1'b0;
        cor_angle    = 36'(h_reg) <<< 17;
        mul_a        = '0;
        mul_b        = '0;
        unique case (state_reg)
            LN_IDLE, LN_DONE:
            begin
                if (start)
                    state_next = LN_LOAD;
            end
            LN_LOAD:
            begin
                if (w_reg == '0)
                    state_next = LN_HEAD;
                else
                    state_next = LN_TDIV;
            end
            LN_TDIV:   state_next = LN_TANG;
            LN_TANG:
            begin
                cor_angle  = w_reg[12] ? -$signed(36'(turn_reg)) : $signed(36'(turn_reg));
                cor_start  = 1'b1;
                state_next = LN_TCOR;
            end
            LN_TCOR:
            begin
                if (cor_done)
                    state_next = LN_MS;
            end
            LN_MS:
            begin
                mul_a      = kv;
                mul_b      = s_reg;
                state_next = LN_DXS;
            end
            LN_DXS:
            begin
                div_start  = 1'b1;
                state_next = LN_DXW;
            end
            LN_DXW:
            begin
                if (div_done)
                    state_next = LN_MC;
            end
            LN_MC:
            begin
                mul_a      = kv;
                mul_b      = 34'(Q30_ONE) - c_reg;
                state_next = LN_DYS;
            end
            LN_DYS:
            begin
                div_start  = 1'b1;
                state_next = LN_DYW;
            end
            LN_DYW:
            begin
                if (div_done)
                    state_next = LN_HEAD;
            end
            LN_HEAD:
            begin
                cor_start  = 1'b1;
                state_next = LN_HCOR;
            end
            LN_HCOR:
            begin
                if (cor_done)
                    state_next = LN_R1;
            end
            LN_R1:
            begin
                mul_a      = dx_reg;
                mul_b      = c_reg;
                state_next = LN_R2;
            end
            LN_R2:
            begin
                mul_a      = dy_reg;
                mul_b      = s_reg;
                state_next = LN_R3;
            end
            LN_R3:
            begin
                mul_a      = dx_reg;
                mul_b      = s_reg;
                state_next = LN_R4;
            end
            LN_R4:
            begin
                mul_a      = dy_reg;
                mul_b      = c_reg;
                state_next = LN_R5;
            end
            LN_R5:   state_next = LN_DONE;
            default: state_next = LN_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= LN_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if ((state_reg == LN_IDLE || state_reg == LN_DONE) && start)
        begin
            x_reg <= pos_x;
            y_reg <= pos_y;
            h_reg <= heading;
            v_reg <= speed;
            w_reg <= turn_rate;
        end
        if (state_reg == LN_LOAD && w_reg == '0)
        begin
            // straight line: 4.5 s in Q4 mm
            dx_reg <= 34'(v_reg) * 34'sd72;
            dy_reg <= '0;
        end
        if (state_reg == LN_LOAD)
        begin
            turn_frac_reg <= 23'(turn_n * TURN_FRAC);
            turn_base_reg <= 35'(turn_n) * 35'(TURN_INT);
        end
        if (state_reg == LN_TDIV)
            turn_reg <= turn_base_reg + 35'(turn_prod[46:30]);
        if ((state_reg == LN_TCOR || state_reg == LN_HCOR) && cor_done)
        begin
            c_reg <= cor_cos;
            s_reg <= cor_sin;
        end
        if (state_reg == LN_DXS || state_reg == LN_DYS)
            sgn_reg <= prod_reg[67] ^ w_reg[12];
        if (state_reg == LN_DXW && div_done)
            dx_reg <= quo_s;
        if (state_reg == LN_DYW && div_done)
            dy_reg <= quo_s;
        if (state_reg == LN_R2 || state_reg == LN_R4)
            acc_reg <= prod_reg;
        if (state_reg == LN_R3)
            px_reg <= 32'((68'(x_reg) <<< 4) + tshr(acc_reg - prod_reg, 6'd30));
        if (state_reg == LN_R5)
            py_reg <= 32'((68'(y_reg) <<< 4) + tshr(acc_reg + prod_reg, 6'd30));
    end

    assign res.done = (state_reg == LN_DONE);
    assign res.px   = px_reg;
    assign res.py   = py_reg;

endmodule

// ----- src/rcp_merge.sv -----
// Merge stage: squared distances now and after 4.5 s, and the approach test.
// One shared squarer stepped over states MG_S1 to MG_S5; depends on rcp_pkg.
`timescale 1ns / 1ps

module rcp_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [23:0]  own_x,
    input  logic signed [23:0]  own_y,
    input  logic signed [23:0]  peer_x,
    input  logic signed [23:0]  peer_y,
    input  rcp_pkg::lane_res_t  own_pred,
    input  rcp_pkg::lane_res_t  peer_pred,
    output rcp_pkg::merge_res_t res
);
    import rcp_pkg::*;

    merge_state_t       state_reg, state_next;
    logic [65:0]        sq_reg;
    logic [66:0]        sum_reg;
    logic [66:0]        now_reg;
    logic               near_reg;
    logic signed [32:0] op;
    logic [66:0]        total;

    assign total = sum_reg + 67'(sq_reg);

    always_comb
    begin
        state_next = state_reg;
        op         = '0;
        unique case (state_reg)
            MG_IDLE, MG_DONE:
            begin
                if (start)
                    state_next = MG_S1;
            end
            MG_S1:
            begin
                op         = 33'(own_x - peer_x) <<< 4;
                state_next = MG_S2;
            end
            MG_S2:
            begin
                op         = 33'(own_y - peer_y) <<< 4;
                state_next = MG_S3;
            end
            MG_S3:
            begin
                op         = 33'(own_pred.px - peer_pred.px);
                state_next = MG_S4;
            end
            MG_S4:
            begin
                op         = 33'(own_pred.py - peer_pred.py);
                state_next = MG_S5;
            end
            MG_S5:   state_next = MG_DONE;
            default: state_next = MG_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= MG_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        sq_reg <= 66'(op * op);
        if (state_reg == MG_S2 || state_reg == MG_S4)
            sum_reg <= 67'(sq_reg);
        if (state_reg == MG_S3)
            now_reg <= total;
        if (state_reg == MG_S5)
            near_reg <= (now_reg > total) && (now_reg < NEAR_SQ);
    end

    assign res.done = (state_reg == MG_DONE);
    assign res.near = near_reg;

endmodule

// ----- src/rcp_checker.sv -----
// Port-level assertions for robot_collision_predictor_top, bound to it below.
// Sees only the top-level ports; depends on nothing else.
`timescale 1ns / 1ps

module rcp_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic skipped,
    input logic approaching,
    input logic stop_and_wait,
    input logic deadlock
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new request taken while one is in work");

    a_skip_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && skipped |-> !approaching && !stop_and_wait && !deadlock)
        else $error("skipped result carries flags");

    a_wait_needs_approach: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (stop_and_wait || deadlock) |-> approaching)
        else $error("wait or deadlock without approach");

endmodule

bind robot_collision_predictor_top rcp_checker u_rcp_checker (.*);

// ----- dv/testbench.sv -----
// Testbench for robot_collision_predictor_top: random and directed collision checks.
// Predicts every result with an in-bench arc/CORDIC model; depends on rcp_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import rcp_pkg::*;

    localparam int  TICK_LIMIT = 20000;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint HPI_Q30 = 64'sd1686629713;
    localparam longint TPI_Q30 = 64'sd6746518852;
    localparam longint GAIN_Q30 = 64'sd652032874;
    localparam longint NEAR_LIMIT = 64'sd1600000000;

    typedef struct {
        logic [2:0]         other;
        logic signed [23:0] ox, oy, qx, qy;
        logic signed [15:0] oh, qh;
        logic signed [12:0] ov, ow, qv, qw;
        logic               drv;
    } check_req_t;

    typedef struct {
        logic skip, near, halt, dead;
    } verdict_t;

    typedef struct {
        logic [1:0]  idx;
        logic [15:0] data;
    } reg_write_t;

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid, in_ready;
    logic [2:0] other_index;
    logic signed [23:0] own_x, own_y, peer_x, peer_y;
    logic signed [15:0] own_heading, peer_heading;
    logic signed [12:0] own_speed, own_turn_rate, peer_speed, peer_turn_rate;
    logic driving;
    logic out_valid, out_ready;
    logic skipped, approaching, stop_and_wait, deadlock;

    robot_collision_predictor_top u_dut (.*);

    check_req_t pending_reqs[$];
    verdict_t   expected_verdicts[$];
    reg_write_t pending_writes[$];

    // predictor state
    logic [2:0]  own_idx_m;
    logic [15:0] tick_m, limit_m;
    int unsigned timer_m[ROBOT_COUNT];

    int errors, n_checked, n_near, n_dead, idle_cycles;
    int burst_left, gap_left;
    logic feed_enable;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, n_checked);
        errors++;
    endtask

    // append a request to the driver queue
    task automatic queue_req(input check_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    function automatic void cordic_sc(input longint ang, output longint c, output longint s);
        longint x, y, z, nx, d;
        bit flip;
        x = GAIN_Q30; y = 0; flip = 0;
        ang = ang % TPI_Q30;
        if (ang > PI_Q30) ang -= TPI_Q30;
        if (ang < -PI_Q30) ang += TPI_Q30;
        if (ang > HPI_Q30) begin ang = PI_Q30 - ang; flip = 1; end
        else if (ang < -HPI_Q30) begin ang = -PI_Q30 - ang; flip = 1; end
        z = ang;
        for (int i = 0; i < 30; i++)
        begin
            d = 64'sd1 <<< i;
            if (z >= 0)
            begin
                nx = x - y / d; y = y + x / d; z -= atan_q30(5'(i));
            end
            else
            begin
                nx = x + y / d; y = y - x / d; z += atan_q30(5'(i));
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = y;
    endfunction

    function automatic void project_pose(input longint x, y, h, v, w,
                                         output longint px, py);
        longint dx, dy, c, s, ch, sh, den;
        if (w == 0)
        begin
            dx = v * 72; dy = 0;
        end
        else
        begin
            den = w * 64'sd67108864;
            cordic_sc((w * 64'sd9663676416) / 2000, c, s);
            dx = (1000 * v * s) / den;
            dy = (1000 * v * (ONE_Q30 - c)) / den;
        end
        cordic_sc(h * 131072, ch, sh);
        px = x * 16 + (dx * ch - dy * sh) / ONE_Q30;
        py = y * 16 + (dx * sh + dy * ch) / ONE_Q30;
    endfunction

    function automatic verdict_t predict_verdict(input check_req_t r);
        verdict_t vd;
        longint ex, ey, now_sq, next_sq, ax, ay, bx, by;
        int unsigned t;
        vd = '{0, 0, 0, 0};
        if (!r.drv) foreach (timer_m[i]) timer_m[i] = 0;
        if (r.other == own_idx_m || r.other >= ROBOT_COUNT)
        begin
            vd.skip = 1;
            return vd;
        end
        ex = (longint'(r.ox) - r.qx) * 16;
        ey = (longint'(r.oy) - r.qy) * 16;
        now_sq = ex * ex + ey * ey;
        project_pose(r.ox, r.oy, r.oh, r.ov, r.ow, ax, ay);
        project_pose(r.qx, r.qy, r.qh, r.qv, r.qw, bx, by);
        ex = ax - bx; ey = ay - by;
        next_sq = ex * ex + ey * ey;
        vd.near = (now_sq > next_sq) && (now_sq < NEAR_LIMIT);
        if (vd.near && timer_m[r.other] < limit_m)
        begin
            t = timer_m[r.other] + tick_m;
            if (t > 65535) t = 65535;
            timer_m[r.other] = t;
            vd.halt = own_idx_m > r.other;
            vd.dead = t > limit_m;
        end
        else
            foreach (timer_m[i]) timer_m[i] = 0;
        return vd;
    endfunction

    function automatic check_req_t rand_req(input bit close);
        check_req_t r;
        r.other = 3'($urandom);
        r.ox = 24'($urandom);
        r.oy = 24'($urandom);
        if (close)
        begin
            r.qx = r.ox + 24'($signed($urandom_range(0, 3000)) - 1500);
            r.qy = r.oy + 24'($signed($urandom_range(0, 3000)) - 1500);
        end
        else
        begin
            r.qx = 24'($urandom); r.qy = 24'($urandom);
        end
        r.oh = 16'($signed($urandom_range(0, 51472)) - 25736);
        r.qh = 16'($signed($urandom_range(0, 51472)) - 25736);
        r.ov = 13'($signed($urandom_range(0, 8000)) - 4000);
        r.qv = 13'($signed($urandom_range(0, 8000)) - 4000);
        r.ow = ($urandom_range(0, 3) == 0) ? 13'sd0 : 13'($signed($urandom_range(0, 8000)) - 4000);
        r.qw = ($urandom_range(0, 3) == 0) ? 13'sd0 : 13'($signed($urandom_range(0, 8000)) - 4000);
        r.drv = $urandom_range(0, 15) != 0;
        return r;
    endfunction

    // driver: config writes and requests, sender in bursts with gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 0; cfg_index <= CFG_OWN_INDEX; cfg_data <= '0;
            in_valid <= 0; other_index <= '0; own_x <= '0; own_y <= '0;
            own_heading <= '0; own_speed <= '0; own_turn_rate <= '0;
            peer_x <= '0; peer_y <= '0; peer_heading <= '0; peer_speed <= '0;
            peer_turn_rate <= '0; driving <= 0;
            burst_left <= 0; gap_left <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OWN_INDEX:      own_idx_m = cfg_data[2:0];
                    CFG_TICK_MS:        tick_m = {6'd0, cfg_data[9:0]};
                    CFG_DEADLOCK_LIMIT: limit_m = cfg_data;
                    default: ;
                endcase
            end
            if (pending_writes.size() > 0 && (!cfg_valid || cfg_ready))
            begin
                reg_write_t w;
                w = pending_writes.pop_front();
                cfg_valid <= 1; cfg_index <= w.idx; cfg_data <= w.data;
            end
            else if (cfg_ready)
                cfg_valid <= 0;

            if (in_valid && in_ready)
                expected_verdicts.insert(expected_verdicts.size(),
                    predict_verdict('{other_index, own_x, own_y,
                    peer_x, peer_y, own_heading, peer_heading, own_speed, own_turn_rate,
                    peer_speed, peer_turn_rate, driving}));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 0;
                end
                else if (feed_enable && pending_reqs.size() > 0)
                begin
                    check_req_t r;
                    r = pending_reqs.pop_front();
                    in_valid <= 1;
                    other_index <= r.other; own_x <= r.ox; own_y <= r.oy;
                    own_heading <= r.oh; own_speed <= r.ov; own_turn_rate <= r.ow;
                    peer_x <= r.qx; peer_y <= r.qy; peer_heading <= r.qh;
                    peer_speed <= r.qv; peer_turn_rate <= r.qw; driving <= r.drv;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(0, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
                    end
                end
                else
                    in_valid <= 0;
            end
        end
    end

    // monitor, receiver stall pattern and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            out_ready <= (n_checked / 150) % 3 == 0 ? 1'b1 : ($urandom_range(0, 7) > 2);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > TICK_LIMIT)
            begin
                $display("Timeout waiting for handshake");
                $display("Some tests failed");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("Unexpected result");
                    errors++;
                end
                else
                begin
                    verdict_t e;
                    e = expected_verdicts.pop_front();
                    if (skipped !== e.skip) report_mismatch("skipped", skipped, e.skip);
                    if (approaching !== e.near) report_mismatch("approaching", approaching, e.near);
                    if (stop_and_wait !== e.halt) report_mismatch("stop_and_wait", stop_and_wait, e.halt);
                    if (deadlock !== e.dead) report_mismatch("deadlock", deadlock, e.dead);
                    n_near += e.near;
                    n_dead += e.dead;
                end
                n_checked++;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        reg_write_t w;
        w.idx = idx;
        w.data = data;
        pending_writes.insert(pending_writes.size(), w);
        wait (pending_writes.size() == 0);
        @(posedge clk);
        @(posedge clk);
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && !in_valid && expected_verdicts.size() == 0);
        repeat (250) @(posedge clk);
    endtask

    // an approaching pair: close, own robot driving straight at a resting peer
    function automatic check_req_t closing_req(input logic [2:0] oth);
        check_req_t r;
        r = rand_req(0);
        r.other = oth; r.qx = r.ox + 24'sd800; r.qy = r.oy;
        r.oh = 0; r.ov = 13'sd100; r.ow = 0; r.qv = 0; r.qw = 0; r.drv = 1;
        return r;
    endfunction

    initial
    begin
        check_req_t r;
        errors = 0; n_checked = 0; n_near = 0; n_dead = 0; feed_enable = 0;
        own_idx_m = 0; tick_m = 100; limit_m = 5000;
        foreach (timer_m[i]) timer_m[i] = 0;
        rst_n = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        feed_enable = 1;

        // directed: extremes, self check, straight line, deadlock build-up
        r = closing_req(1); r.other = 0; queue_req(r);
        r = rand_req(1);
        r.ox = 24'sh7FFFFF; r.oy = -24'sh800000; r.qx = -24'sh800000; r.qy = 24'sh7FFFFF;
        r.oh = 16'sd25736; r.qh = -16'sd25736; r.ov = 13'sd4000; r.qv = -13'sd4000;
        r.ow = -13'sd4000; r.qw = 13'sd4000; r.other = 3'd7;
        queue_req(r);
        r.ox = 0; r.oy = 0; r.qx = 24'sd10; r.qy = 0; r.ow = 13'sd1; r.qw = -13'sd1;
        queue_req(r);
        for (int i = 0; i < 4; i++) queue_req(closing_req(3'd2));
        r = closing_req(3'd2); r.drv = 0; queue_req(r);
        drain();
        write_reg(CFG_OWN_INDEX, 16'd5);
        write_reg(CFG_TICK_MS, 16'd1000);
        write_reg(CFG_DEADLOCK_LIMIT, 16'd2500);
        for (int i = 0; i < 6; i++) queue_req(closing_req(3'd3));
        queue_req(closing_req(3'd5));
        for (int i = 0; i < 3; i++) queue_req(closing_req(3'd6));
        drain();

        // random phases across register settings
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_TICK_MS, 16'd1); write_reg(CFG_DEADLOCK_LIMIT, 16'd1); end
                1: begin write_reg(CFG_TICK_MS, 16'd1023); write_reg(CFG_DEADLOCK_LIMIT, 16'd60000); end
                2: begin write_reg(CFG_OWN_INDEX, 16'd7); write_reg(CFG_DEADLOCK_LIMIT, 16'hFFFF); end
                default:
                begin
                    write_reg(CFG_OWN_INDEX, 16'($urandom));
                    write_reg(CFG_TICK_MS, 16'($urandom));
                    write_reg(CFG_DEADLOCK_LIMIT, 16'($urandom));
                end
            endcase
            for (int i = 0; i < 200; i++)
            begin
                if ($urandom_range(0, 3) == 0)
                    queue_req(closing_req(3'($urandom)));
                else
                    queue_req(rand_req($urandom_range(0, 2) != 0));
            end
            drain();
        end

        $display("Checked %0d results: %0d approaching, %0d deadlocks, over several settings",
                 n_checked, n_near, n_dead);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
